### hw/rtl/tcpm_pkg.sv
// Shared types, register codes, reset values and elaboration-time helpers
// for the throttle curve pulse mapper. No dependencies.
`timescale 1ns / 1ps

package tcpm_pkg;

  // default widths
  localparam int FRAC_BITS_DEF  = 16;
  localparam int PULSE_BITS_DEF = 12;

  // fixed field widths
  localparam int PCT_W     = 8;
  localparam int DB_W      = 7;
  localparam int MODE_W    = 2;
  localparam int EXPO_W    = 9;
  localparam int CFG_IDX_W = 3;

  localparam logic [DB_W-1:0]   PCT_FULL  = 7'd100;
  localparam logic [EXPO_W-1:0] EXPO_ONE  = 9'd256;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEADBAND = 3'd0,
    REG_NEUTRAL  = 3'd1,
    REG_MIN      = 3'd2,
    REG_MAX      = 3'd3,
    REG_MODE     = 3'd4,
    REG_EXPO     = 3'd5
  } cfg_reg_t;

  // curve select; the reserved code behaves as linear
  typedef enum logic [MODE_W-1:0] {
    CURVE_LINEAR = 2'd0,
    CURVE_SOFT   = 2'd1,
    CURVE_PROG   = 2'd2,
    CURVE_RSVD   = 2'd3
  } curve_mode_t;

  // reset values
  localparam int RST_NEUTRAL = 1500;
  localparam int RST_MIN     = 1000;
  localparam int RST_MAX     = 2000;

  // config data width covers the widest register
  function automatic int cfg_width(input int pulse_bits);
    return (pulse_bits > EXPO_W) ? pulse_bits : EXPO_W;
  endfunction

  // number of register stages in the soft start pipeline
  function automatic int soft_latency(input int frac_bits);
    return 3 * frac_bits + 5;
  endfunction

  // integer square root, elaboration use only
  function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      b = 64'd1 << (62 - 2 * i);
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  // 2^(2^-k) in Q.frac, repeated square roots of two
  function automatic logic [63:0] exp_coef(input int frac_bits, input int k);
    logic [63:0] c;
    c = int_sqrt(64'd2 << (2 * frac_bits));
    for (int j = 1; j < k; j++) begin
      c = int_sqrt(c << frac_bits);
    end
    return c;
  endfunction

endpackage

### hw/rtl/tcpm_soft_start.sv
// Soft start power curve pipeline: y = x^(1+2e) via -log2, scale, exp2 and
// a reciprocal divide. Fixed latency, advances on en. Depends on tcpm_pkg.
`timescale 1ns / 1ps

module tcpm_soft_start #(
  parameter int FRAC_BITS = tcpm_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [FRAC_BITS:0]           x_i,
  input  logic [tcpm_pkg::EXPO_W-1:0]  expo_i,
  output logic [FRAC_BITS:0]           y_o
);
  import tcpm_pkg::*;

  localparam int F  = FRAC_BITS;
  localparam int NW = $clog2(F + 1);
  localparam int MW = NW + F;
  localparam int QW = MW + 2;
  localparam int IW = QW - F;
  localparam logic [F:0]   ONE   = (F + 1)'(1) << F;
  localparam logic [F+1:0] DIVHI = (F + 2)'(1) << F;

  typedef struct packed {
    logic [NW-1:0] n;
    logic [F:0]    z;
    logic [F-1:0]  f;
  } sq_t;

  typedef struct packed {
    logic [IW-1:0] qi;
    logic [F-1:0]  qf;
    logic [F:0]    g;
  } ex_t;

  typedef struct packed {
    logic [IW-1:0] qi;
    logic [F:0]    g;
    logic [F+1:0]  rem;
    logic [F:0]    quo;
  } dv_t;

  sq_t           sq_r  [0:F];
  sq_t           sq_nxt[0:F];
  logic [MW-1:0] m_r, m_nxt;
  ex_t           ex_r  [0:F];
  ex_t           ex_nxt[0:F];
  dv_t           dv_r  [0:F];
  dv_t           dv_nxt[0:F];
  logic [F:0]    y_r, y_nxt;
  logic [F:0]    coef  [1:F];
  logic [NW-1:0] msb;
  logic [9:0]    pw;
  logic [MW+9:0] mprod;

  // exp2 coefficients, fixed at elaboration
  for (genvar k = 1; k <= F; k++) begin : g_coef
    localparam logic [63:0] CK = exp_coef(F, k);
    assign coef[k] = CK[F:0];
  end

  // normalize x to [1,2) and run the squaring log2 steps
  always_comb begin
    logic [2*F+1:0] prod;
    logic [F+1:0]   zs;
    msb = '0;
    for (int i = 0; i <= F; i++) begin
      if (x_i[i]) msb = NW'(i);
    end
    sq_nxt[0].n = NW'(F) - msb;
    sq_nxt[0].z = x_i << sq_nxt[0].n;
    sq_nxt[0].f = '0;
    for (int i = 1; i <= F; i++) begin
      prod = (2*F+2)'(sq_r[i-1].z) * (2*F+2)'(sq_r[i-1].z);
      zs   = prod[2*F+1:F];
      sq_nxt[i].n = sq_r[i-1].n;
      sq_nxt[i].z = zs[F+1] ? zs[F+1:1] : zs[F:0];
      sq_nxt[i].f = {sq_r[i-1].f[F-2:0], zs[F+1]};
    end
  end

  // m = -log2(x), then scale by the power 1 + 2e
  assign m_nxt = (MW'(sq_r[F].n) << F) - MW'(sq_r[F].f);
  assign pw    = 10'd256 + 10'({expo_i, 1'b0});
  assign mprod = (MW+10)'(m_r) * (MW+10)'(pw);

  // exp2 of the fraction, one coefficient per stage
  always_comb begin
    logic [2*F+1:0] gp;
    ex_nxt[0].qi = mprod[MW+9:F+8];
    ex_nxt[0].qf = mprod[F+7:8];
    ex_nxt[0].g  = ONE;
    for (int k = 1; k <= F; k++) begin
      gp = (2*F+2)'(ex_r[k-1].g) * (2*F+2)'(coef[k]);
      ex_nxt[k] = ex_r[k-1];
      if (ex_r[k-1].qf[F-k]) ex_nxt[k].g = gp[2*F:F];
    end
  end

  // reciprocal 2^(2F) / g, one quotient bit per stage
  always_comb begin
    logic [F+1:0] r;
    logic         b;
    r = DIVHI;
    b = (r >= (F+2)'(ex_r[F].g));
    dv_nxt[0].qi  = ex_r[F].qi;
    dv_nxt[0].g   = ex_r[F].g;
    dv_nxt[0].rem = b ? r - (F+2)'(ex_r[F].g) : r;
    dv_nxt[0].quo = (F+1)'(b);
    for (int j = 1; j <= F; j++) begin
      r = {dv_r[j-1].rem[F:0], 1'b0};
      b = (r >= (F+2)'(dv_r[j-1].g));
      dv_nxt[j].qi  = dv_r[j-1].qi;
      dv_nxt[j].g   = dv_r[j-1].g;
      dv_nxt[j].rem = b ? r - (F+2)'(dv_r[j-1].g) : r;
      dv_nxt[j].quo = {dv_r[j-1].quo[F-1:0], b};
    end
  end

  // integer part of the exponent is a right shift
  assign y_nxt = (dv_r[F].qi > IW'(F)) ? '0 : (dv_r[F].quo >> dv_r[F].qi);

  // stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i <= F; i++) begin
        sq_r[i] <= sq_nxt[i];
        ex_r[i] <= ex_nxt[i];
        dv_r[i] <= dv_nxt[i];
      end
      m_r <= m_nxt;
      y_r <= y_nxt;
    end
  end

  assign y_o = y_r;

endmodule

### hw/rtl/throttle_curve_pulse_mapper.sv
// Throttle percent to servo pulse mapper, top level: config registers,
// normalizing divider, curves, interpolation. Depends on tcpm_pkg, tcpm_soft_start.
`timescale 1ns / 1ps

// One throttle beat in, one pulse beat out, in order. The pipeline takes a new
// beat every cycle unless the output stalls; its depth is set mostly by the soft
// start path: one squaring, one exp2 multiply or one quotient bit per stage.
// Every curve runs for every beat and the configured one is picked at the end.
// The whole pipeline holds while a result waits on out_ready. Configuration must
// be written only while no beat is in flight; the block does not enforce this.

module throttle_curve_pulse_mapper #(
  parameter int FRAC_BITS  = tcpm_pkg::FRAC_BITS_DEF,
  parameter int PULSE_BITS = tcpm_pkg::PULSE_BITS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            cfg_valid,
  output logic                                            cfg_ready,
  input  logic [tcpm_pkg::CFG_IDX_W-1:0]                  cfg_index,
  input  logic [tcpm_pkg::cfg_width(PULSE_BITS)-1:0]      cfg_data,
  input  logic                                            in_valid,
  output logic                                            in_ready,
  input  logic [tcpm_pkg::PCT_W-1:0]                      in_throttle_pct,
  output logic                                            out_valid,
  input  logic                                            out_ready,
  output logic [PULSE_BITS-1:0]                           out_pulse_us,
  output logic                                            out_in_deadband
);
  import tcpm_pkg::*;

  localparam int F  = FRAC_BITS;
  localparam int PB = PULSE_BITS;
  localparam int LS = soft_latency(F);
  localparam int PW = PB + F + 1;
  localparam logic [F:0] ONE = (F + 1)'(1) << F;

  typedef struct packed {
    logic            vld;
    logic            dead;
    logic [DB_W:0]   rem;
    logic [DB_W-1:0] dv;
  } in_t;

  typedef struct packed {
    logic            vld;
    logic            dead;
    logic [DB_W:0]   rem;
    logic [DB_W-1:0] dv;
    logic [F:0]      quo;
  } div_t;

  typedef struct packed {
    logic         vld;
    logic         dead;
    logic [F:0]   x;
    logic [F:0]   x2;
    logic [F+1:0] s;
    logic [F:0]   yp;
  } cur_t;

  typedef struct packed {
    logic          vld;
    logic          dead;
    logic [PW-1:0] plo;
    logic [PW-1:0] phi;
  } mix_t;

  typedef struct packed {
    logic          vld;
    logic          dead;
    logic [PB-1:0] pulse;
  } out_t;

  // configuration registers
  logic [DB_W-1:0]   db_r;
  logic [PB-1:0]     neutral_r, min_r, max_r;
  curve_mode_t       mode_r;
  logic [EXPO_W-1:0] expo_r;
  logic [EXPO_W-1:0] expo_c;

  in_t  in_r,  in_nxt;
  div_t div_r  [0:F];
  div_t div_nxt[0:F];
  cur_t cur_r  [0:LS-1];
  cur_t cur_nxt[0:LS-1];
  mix_t mix_r, mix_nxt;
  out_t out_r, out_nxt;
  logic [F:0] ys;
  logic       en;

  // config write port, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      db_r      <= '0;
      neutral_r <= PB'(RST_NEUTRAL);
      min_r     <= PB'(RST_MIN);
      max_r     <= PB'(RST_MAX);
      mode_r    <= CURVE_LINEAR;
      expo_r    <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_DEADBAND: db_r      <= cfg_data[DB_W-1:0];
        REG_NEUTRAL:  neutral_r <= cfg_data[PB-1:0];
        REG_MIN:      min_r     <= cfg_data[PB-1:0];
        REG_MAX:      max_r     <= cfg_data[PB-1:0];
        REG_MODE:     mode_r    <= curve_mode_t'(cfg_data[MODE_W-1:0]);
        REG_EXPO:     expo_r    <= cfg_data[EXPO_W-1:0];
        default: ;
      endcase
    end
  end

  assign expo_c = (expo_r > EXPO_ONE) ? EXPO_ONE : expo_r;

  // global advance: hold everything while the output beat waits
  assign en       = !out_r.vld || out_ready;
  assign in_ready = en;

  // input stage: saturate, deadband test, divider operands
  always_comb begin
    logic [DB_W-1:0] t;
    t = (in_throttle_pct > PCT_W'(PCT_FULL)) ? PCT_FULL : in_throttle_pct[DB_W-1:0];
    in_nxt.vld  = in_valid;
    in_nxt.dead = (t <= db_r);
    in_nxt.rem  = (DB_W+1)'(t - db_r);
    in_nxt.dv   = PCT_FULL - db_r;
  end

  // normalizing divider, one quotient bit per stage
  always_comb begin
    logic [DB_W:0] r;
    logic          b;
    r = in_r.rem;
    b = (r >= (DB_W+1)'(in_r.dv));
    div_nxt[0].vld  = in_r.vld;
    div_nxt[0].dead = in_r.dead;
    div_nxt[0].dv   = in_r.dv;
    div_nxt[0].rem  = b ? r - (DB_W+1)'(in_r.dv) : r;
    div_nxt[0].quo  = (F+1)'(b);
    for (int j = 1; j <= F; j++) begin
      r = {div_r[j-1].rem[DB_W-1:0], 1'b0};
      b = (r >= (DB_W+1)'(div_r[j-1].dv));
      div_nxt[j].vld  = div_r[j-1].vld;
      div_nxt[j].dead = div_r[j-1].dead;
      div_nxt[j].dv   = div_r[j-1].dv;
      div_nxt[j].rem  = b ? r - (DB_W+1)'(div_r[j-1].dv) : r;
      div_nxt[j].quo  = {div_r[j-1].quo[F-1:0], b};
    end
  end

  // soft start runs alongside the curve delay line
  tcpm_soft_start #(
    .FRAC_BITS (F)
  ) u_soft (
    .clk    (clk),
    .en     (en),
    .x_i    (div_r[F].quo),
    .expo_i (expo_c),
    .y_o    (ys)
  );

  // progressive blend in the first three stages, then delay to match soft start
  always_comb begin
    logic [2*F+1:0] xx;
    logic [F+2:0]   tri_w;
    logic [2*F+4:0] sp;
    logic [F+11:0]  blend;
    logic [F+3:0]   yb;
    xx = (2*F+2)'(div_r[F].quo) * (2*F+2)'(div_r[F].quo);
    cur_nxt[0].vld  = div_r[F].vld;
    cur_nxt[0].dead = div_r[F].dead;
    cur_nxt[0].x    = div_r[F].quo;
    cur_nxt[0].x2   = xx[2*F:F];
    cur_nxt[0].s    = '0;
    cur_nxt[0].yp   = '0;

    tri_w = (F+3)'(3) * (F+3)'(ONE) - {1'b0, cur_r[0].x, 1'b0};
    sp    = (2*F+5)'(cur_r[0].x2) * (2*F+5)'(tri_w);
    cur_nxt[1]   = cur_r[0];
    cur_nxt[1].s = sp[2*F+1:F];

    blend = (F+12)'(cur_r[1].x) * (F+12)'(10'd256 - 10'(expo_c))
          + (F+12)'(cur_r[1].s) * (F+12)'(expo_c);
    yb    = blend[F+11:8];
    cur_nxt[2]    = cur_r[1];
    cur_nxt[2].yp = (yb > (F+4)'(ONE)) ? ONE : yb[F:0];

    for (int i = 3; i < LS; i++) begin
      cur_nxt[i] = cur_r[i-1];
    end
  end

  // curve select and the two interpolation products
  always_comb begin
    logic [F:0] y;
    case (mode_r)
      CURVE_SOFT: y = ys;
      CURVE_PROG: y = cur_r[LS-1].yp;
      default:    y = cur_r[LS-1].x;
    endcase
    if (y > ONE) y = ONE;
    mix_nxt.vld  = cur_r[LS-1].vld;
    mix_nxt.dead = cur_r[LS-1].dead;
    mix_nxt.plo  = PW'(min_r) * PW'(ONE - y);
    mix_nxt.phi  = PW'(max_r) * PW'(y);
  end

  // round half up, clamp to the band, neutral inside the deadband
  always_comb begin
    logic [PW:0]   sum;
    logic [PB+1:0] pr;
    logic [PB+1:0] blo, bhi;
    sum = (PW+1)'(mix_r.plo) + (PW+1)'(mix_r.phi) + (PW+1)'(ONE >> 1);
    pr  = sum[PW:F];
    blo = (PB+2)'((min_r < max_r) ? min_r : max_r);
    bhi = (PB+2)'((min_r < max_r) ? max_r : min_r);
    if (pr < blo) pr = blo;
    if (pr > bhi) pr = bhi;
    out_nxt.vld   = mix_r.vld;
    out_nxt.dead  = mix_r.dead;
    out_nxt.pulse = mix_r.dead ? neutral_r : pr[PB-1:0];
  end

  // pipeline registers; only valid bits are reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_r.vld  <= 1'b0;
      mix_r.vld <= 1'b0;
      out_r.vld <= 1'b0;
      for (int j = 0; j <= F; j++) div_r[j].vld <= 1'b0;
      for (int i = 0; i < LS; i++) cur_r[i].vld <= 1'b0;
    end else if (en) begin
      in_r  <= in_nxt;
      mix_r <= mix_nxt;
      out_r <= out_nxt;
      for (int j = 0; j <= F; j++) div_r[j] <= div_nxt[j];
      for (int i = 0; i < LS; i++) cur_r[i] <= cur_nxt[i];
    end
  end

  assign out_valid       = out_r.vld;
  assign out_pulse_us    = out_r.pulse;
  assign out_in_deadband = out_r.dead;

endmodule
